FILE: rtl/core/one_wire_temperature_reader_macros.svh
// Assertion helpers for the bus master checker.
// Each expects clk and rst_n in the scope where it is used.
`ifndef ONE_WIRE_TEMPERATURE_READER_MACROS_SVH
`define ONE_WIRE_TEMPERATURE_READER_MACROS_SVH

// Same-cycle implication.
`define OWTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OWTR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/owtr_pkg.sv
package owtr_pkg;

    localparam int TICK_BITS     = 10;
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int CFG_DATA_W    = 10;
    localparam int CFG_IDX_W     = 3;
    // Wide enough for any duration register and for 2^TICK_BITS itself.
    localparam int DUR_W = ((TICK_BITS > CFG_DATA_W) ? TICK_BITS : CFG_DATA_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SAMPLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;

    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
    localparam logic [7:0] CMD_NONE      = 8'h00;

    typedef struct packed {
        logic [9:0] reset_low_ticks;
        logic [7:0] presence_sample_ticks;
        logic [9:0] reset_tail_ticks;
        logic [7:0] slot_ticks;
        logic [5:0] short_low_ticks;
        logic [7:0] write_zero_low_ticks;
        logic [5:0] read_sample_ticks;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence_seen;
        logic [11:0] temperature;
        logic [15:0] raw_reading;
    } res_t;

    // Byte sent at each step of the sequence; reset and read steps carry none.
    function automatic logic [7:0] cmd_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd1, 3'd4: b = CMD_SKIP_ROM;
            3'd2:       b = CMD_CONVERT;
            3'd5:       b = CMD_READ_PAD;
            default:    b = CMD_NONE;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/owtr_in_if.sv
interface owtr_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic line_level;

    modport source (output valid, output start_req, output line_level, input ready);
    modport sink (input valid, input start_req, input line_level, output ready);
endinterface

FILE: rtl/core/owtr_out_if.sv
interface owtr_out_if;
    logic        valid;
    logic        ready;
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        presence_seen;
    logic [11:0] temperature;
    logic [15:0] raw_reading;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence_seen, output temperature, output raw_reading,
                    input ready);
    modport sink (input valid, input drive_low, input busy_res, input done_res,
                  input presence_seen, input temperature, input raw_reading,
                  output ready);
endinterface

FILE: rtl/core/one_wire_temperature_reader.sv
// Channel   Dir  Beat payload
// in_ch     in   start_req, line_level (one bus tick per beat)
// out_ch    out  drive_low, busy_res, done_res, presence_seen, temperature, raw_reading
// cfg_*     in   plain register write, no read-back
//
// One beat in, one beat out, one cycle per beat; the sequencer state and the
// output register both advance on an accepted input beat.
// A new input beat is taken while the output register is empty or being drained.
// The output beat is registered and is offered in the cycle after its input beat is accepted.
// rst_n clears the sequencer to idle, the held readings to zero and the
// timing registers to their default values.
module one_wire_temperature_reader
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0] cfg_data,
    owtr_in_if.sink                         in_ch,
    owtr_out_if.source                      out_ch
);

    owtr_pkg::cfg_t cfg;
    owtr_pkg::res_t res;
    owtr_pkg::res_t res_reg;
    logic           out_valid_reg, out_valid_next;
    logic           step_en;

    owtr_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owtr_seq u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (step_en),
        .start_req  (in_ch.start_req),
        .line_level (in_ch.line_level),
        .cfg        (cfg),
        .res        (res)
    );

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step_en     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Hold the result beat until the sink takes it.
    always_ff @(posedge clk)
    begin
        if (step_en)
            res_reg <= res;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.drive_low     = res_reg.drive_low;
    assign out_ch.busy_res      = res_reg.busy_res;
    assign out_ch.done_res      = res_reg.done_res;
    assign out_ch.presence_seen = res_reg.presence_seen;
    assign out_ch.temperature   = res_reg.temperature;
    assign out_ch.raw_reading   = res_reg.raw_reading;

endmodule

FILE: rtl/core/owtr_cfg.sv
module owtr_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output owtr_pkg::cfg_t                   cfg
);

    owtr_pkg::cfg_t cfg_reg;
    owtr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                owtr_pkg::REG_RESET_LOW:       cfg_next.reset_low_ticks       = cfg_data[9:0];
                owtr_pkg::REG_PRESENCE_SAMPLE: cfg_next.presence_sample_ticks = cfg_data[7:0];
                owtr_pkg::REG_RESET_TAIL:      cfg_next.reset_tail_ticks      = cfg_data[9:0];
                owtr_pkg::REG_SLOT:            cfg_next.slot_ticks            = cfg_data[7:0];
                owtr_pkg::REG_SHORT_LOW:       cfg_next.short_low_ticks       = cfg_data[5:0];
                owtr_pkg::REG_WRITE_ZERO_LOW:  cfg_next.write_zero_low_ticks  = cfg_data[7:0];
                owtr_pkg::REG_READ_SAMPLE:     cfg_next.read_sample_ticks     = cfg_data[5:0];
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_ticks       <= 10'd480;
            cfg_reg.presence_sample_ticks <= 8'd70;
            cfg_reg.reset_tail_ticks      <= 10'd410;
            cfg_reg.slot_ticks            <= 8'd70;
            cfg_reg.short_low_ticks       <= 6'd6;
            cfg_reg.write_zero_low_ticks  <= 8'd60;
            cfg_reg.read_sample_ticks     <= 6'd15;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/owtr_seq.sv
module owtr_seq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  logic           start_req,
    input  logic           line_level,
    input  owtr_pkg::cfg_t cfg,
    output owtr_pkg::res_t res
);

    localparam int TB  = owtr_pkg::TICK_BITS;
    localparam int DW  = owtr_pkg::DUR_W;
    localparam int BW  = owtr_pkg::BIT_IDX_W;
    localparam logic [BW-1:0] BIT_LAST = BW'(owtr_pkg::BITS_PER_BYTE - 1);
    localparam logic [DW-1:0] TICK_LIM = DW'(1) << TB;

    localparam logic [2:0] STEP_FIRST_RESET = 3'd0;
    localparam logic [2:0] STEP_SECOND_RESET = 3'd3;
    localparam logic [2:0] STEP_READ_LOW    = 3'd6;
    localparam logic [2:0] STEP_LAST        = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RESET_LOW,
        PH_RESET_WAIT,
        PH_RESET_TAIL,
        PH_WRITE,
        PH_READ
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [2:0]      cmd_reg, cmd_next;
    logic [BW-1:0]   bit_reg, bit_next;
    logic [TB-1:0]   tick_reg, tick_next;
    logic [7:0]      shift_reg, shift_next;
    logic [7:0]      low_reg, low_next;
    logic [7:0]      high_reg, high_next;
    logic            pres_reg, pres_next;
    logic [11:0]     temp_reg, temp_next;

    phase_t          ph_cur;
    logic [2:0]      cmd_cur;
    logic [BW-1:0]   bit_cur;
    logic [TB-1:0]   tick_cur;
    logic [7:0]      shift_cur;
    logic            drive, busy, done, slot_end, go_next;
    logic [DW-1:0]   tick_ext, low_len, slot_len, sample_at;
    logic [2:0]      next_idx;

    function automatic phase_t phase_for(input logic [2:0] idx);
        phase_t p;
        if (idx == STEP_FIRST_RESET || idx == STEP_SECOND_RESET)
            p = PH_RESET_LOW;
        else if (idx < STEP_READ_LOW)
            p = PH_WRITE;
        else
            p = PH_READ;
        return p;
    endfunction

    // Length of a phase in ticks: at least one, clipped to the counter range.
    function automatic logic [DW-1:0] span(input logic [DW-1:0] n);
        logic [DW-1:0] s;
        if (n == '0)
            s = DW'(1);
        else if (n > TICK_LIM)
            s = TICK_LIM;
        else
            s = n;
        return s;
    endfunction

    function automatic logic hit(input logic [DW-1:0] t, input logic [DW-1:0] n);
        return (t + DW'(1)) >= span(n);
    endfunction

    always_comb
    begin
        // A start in idle opens the first reset pulse on this same tick.
        if (phase_reg == PH_IDLE && start_req)
        begin
            ph_cur    = PH_RESET_LOW;
            cmd_cur   = STEP_FIRST_RESET;
            bit_cur   = '0;
            tick_cur  = '0;
            shift_cur = owtr_pkg::cmd_byte(STEP_FIRST_RESET);
        end
        else
        begin
            ph_cur    = phase_reg;
            cmd_cur   = cmd_reg;
            bit_cur   = bit_reg;
            tick_cur  = tick_reg;
            shift_cur = shift_reg;
        end

        tick_ext   = DW'(tick_cur);
        slot_len   = span(DW'(cfg.slot_ticks));
        sample_at  = (DW'(cfg.read_sample_ticks) < slot_len) ?
                     DW'(cfg.read_sample_ticks) : (slot_len - DW'(1));
        low_len    = shift_cur[0] ? DW'(cfg.short_low_ticks) : DW'(cfg.write_zero_low_ticks);

        phase_next = ph_cur;
        cmd_next   = cmd_cur;
        bit_next   = bit_cur;
        tick_next  = tick_cur + TB'(1);
        shift_next = shift_cur;
        low_next   = low_reg;
        high_next  = high_reg;
        pres_next  = pres_reg;
        temp_next  = temp_reg;
        drive      = 1'b0;
        busy       = 1'b1;
        done       = 1'b0;
        slot_end   = 1'b0;
        go_next    = 1'b0;

        unique case (ph_cur)
            PH_RESET_LOW:
            begin
                drive = 1'b1;
                if (hit(tick_ext, DW'(cfg.reset_low_ticks)))
                begin
                    tick_next  = '0;
                    phase_next = PH_RESET_WAIT;
                end
            end
            PH_RESET_WAIT:
            begin
                if (tick_ext >= DW'(cfg.presence_sample_ticks) || tick_cur == '1)
                begin
                    pres_next  = ~line_level;
                    tick_next  = '0;
                    phase_next = PH_RESET_TAIL;
                end
            end
            PH_RESET_TAIL:
            begin
                if (hit(tick_ext, DW'(cfg.reset_tail_ticks)))
                    go_next = 1'b1;
            end
            PH_WRITE:
            begin
                drive = tick_ext < low_len;
                if (hit(tick_ext, DW'(cfg.slot_ticks)))
                begin
                    tick_next  = '0;
                    shift_next = {1'b0, shift_cur[7:1]};
                    slot_end   = 1'b1;
                end
            end
            PH_READ:
            begin
                drive = tick_ext < DW'(cfg.short_low_ticks);
                if (tick_ext == sample_at)
                    shift_next = {line_level, shift_cur[7:1]};
                if (hit(tick_ext, DW'(cfg.slot_ticks)))
                begin
                    tick_next = '0;
                    slot_end  = 1'b1;
                end
            end
            default:
            begin
                busy      = 1'b0;
                tick_next = tick_cur;
            end
        endcase

        if (slot_end)
        begin
            if (bit_cur == BIT_LAST)
            begin
                if (ph_cur == PH_READ)
                begin
                    if (cmd_cur == STEP_READ_LOW)
                    begin
                        low_next = shift_next;
                    end
                    else
                    begin
                        high_next = shift_next;
                        temp_next = {shift_next, 4'b0000} + {8'h00, low_reg[7:4]};
                        done      = 1'b1;
                    end
                end
                if (cmd_cur == STEP_LAST)
                begin
                    phase_next = PH_IDLE;
                    cmd_next   = '0;
                    bit_next   = '0;
                end
                else
                begin
                    go_next = 1'b1;
                end
            end
            else
            begin
                bit_next = bit_cur + BW'(1);
            end
        end

        // Open the next step of the sequence.
        next_idx = cmd_cur + 3'd1;
        if (go_next)
        begin
            cmd_next   = next_idx;
            bit_next   = '0;
            tick_next  = '0;
            shift_next = owtr_pkg::cmd_byte(next_idx);
            phase_next = phase_for(next_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= '0;
            bit_reg   <= '0;
            tick_reg  <= '0;
            shift_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            pres_reg  <= 1'b0;
            temp_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bit_reg   <= bit_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            pres_reg  <= pres_next;
            temp_reg  <= temp_next;
        end
    end

    always_comb
    begin
        res.drive_low     = drive;
        res.busy_res      = busy;
        res.done_res      = done;
        res.presence_seen = pres_next;
        res.temperature   = temp_next;
        res.raw_reading   = {high_next, low_next};
    end

endmodule

FILE: rtl/core/owtr_checker.sv
`include "one_wire_temperature_reader_macros.svh"

module owtr_assertions
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_drive_low,
    input logic out_busy,
    input logic out_done
);

    // Output beat stays offered until taken.
    `OWTR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped")

    // An empty output stage never blocks the input.
    `OWTR_ASSERT_IMP(a_in_ready, !out_valid, in_ready, "input stalled with empty output")

    // A finished reading only appears while the sequence runs.
    `OWTR_ASSERT_IMP(a_done_busy, out_valid && out_done, out_busy, "done outside a sequence")

    // Idle never pulls the bus.
    `OWTR_ASSERT_IMP(a_idle_release, out_valid && !out_busy, !out_drive_low,
                     "bus driven while idle")

endmodule

bind one_wire_temperature_reader owtr_assertions u_owtr_assertions
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_drive_low (out_ch.drive_low),
    .out_busy      (out_ch.busy_res),
    .out_done      (out_ch.done_res)
);
